### rtl/mkq_pkg.sv
package mkq_pkg;

    // Default number of records the queue can hold.
    localparam int MKQ_CAPACITY = 16;

    // Field widths fixed by the item format.
    localparam int KEY_W    = 16;
    localparam int STATUS_W = 2;
    localparam int LEFT_W   = 5;

    // Operation codes of an input item.
    localparam logic OP_INSERT  = 1'b0;
    localparam logic OP_EXTRACT = 1'b1;

    // Status codes of a result item.
    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

    // One stored process record.
    typedef struct packed {
        logic [KEY_W-1:0] id;
        logic [KEY_W-1:0] arrival;
        logic [KEY_W-1:0] service;
    } t_rec;

    // Control from the sequencer to the minimum search unit.
    typedef struct packed {
        logic en;
        logic first;
    } t_min_ctl;

endpackage

### rtl/min_key_extract_queue.sv
// Bounded priority queue of process records (id, arrival time, service time).
// Items are issued with start while busy is low, all fields on their own ports.
// An insert appends the record in arrival order; an extract removes the record
// with the smallest id, the oldest one among equal ids.
// Each item gives exactly one result, shown on the o_ ports for one cycle with
// o_valid high: a status, the extracted record (zero unless an extract
// succeeds) and the number of records held afterwards.
// An insert, a full insert or an empty extract answers in the cycle after
// it is accepted and busy stays low, so one such item can be issued every
// cycle. A successful extract first scans the record memory with the single
// comparator, one entry per cycle through its registered read port, then
// moves the entries behind the chosen record down one place per cycle.
// busy is high for that whole time.
// Reset empties the queue; the record memory itself is not cleared.
// The receiver cannot stall: a result must be taken in the cycle it is shown.
module min_key_extract_queue #(
    parameter int CAPACITY = mkq_pkg::MKQ_CAPACITY
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic                            i_op,
    input  logic [mkq_pkg::KEY_W-1:0]       i_process_id,
    input  logic [mkq_pkg::KEY_W-1:0]       i_arrival_time,
    input  logic [mkq_pkg::KEY_W-1:0]       i_service_time,
    output logic                            o_valid,
    output logic [mkq_pkg::STATUS_W-1:0]    o_status,
    output logic [mkq_pkg::KEY_W-1:0]       o_out_id,
    output logic [mkq_pkg::KEY_W-1:0]       o_out_arrival,
    output logic [mkq_pkg::KEY_W-1:0]       o_out_service,
    output logic [mkq_pkg::LEFT_W-1:0]      o_entries_left
);
    import mkq_pkg::*;

    localparam int IDX_W = $clog2(CAPACITY);
    localparam int CNT_W = $clog2(CAPACITY + 1);

    localparam logic [1:0] S_IDLE    = 2'd0;
    localparam logic [1:0] S_SCAN    = 2'd1;
    localparam logic [1:0] S_CSTART  = 2'd2;
    localparam logic [1:0] S_COMPACT = 2'd3;

    logic [1:0]       r_state, n_state;
    logic [CNT_W-1:0] r_count, n_count;
    logic [IDX_W-1:0] r_k, n_k;

    logic                r_valid, n_valid;
    logic [STATUS_W-1:0] r_status, n_status;
    t_rec                r_out, n_out;

    logic             w_accept;
    logic [CNT_W-1:0] w_k_next;
    logic             w_we;
    logic [IDX_W-1:0] w_waddr;
    t_rec             w_wdata;
    logic [IDX_W-1:0] w_raddr;
    t_rec             w_rdata;
    t_min_ctl         w_min_ctl;
    logic [IDX_W-1:0] w_best_idx;
    t_rec             w_best_rec;
    t_rec             w_in_rec;

    assign w_accept = start && !busy;
    assign busy     = (r_state != S_IDLE);
    assign w_k_next = CNT_W'(r_k) + CNT_W'(1);

    assign w_in_rec.id      = i_process_id;
    assign w_in_rec.arrival = i_arrival_time;
    assign w_in_rec.service = i_service_time;

    mkq_store #(
        .CAPACITY (CAPACITY)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    mkq_min_unit #(
        .CAPACITY (CAPACITY)
    ) u_min (
        .i_clk      (i_clk),
        .i_ctl      (w_min_ctl),
        .i_idx      (r_k),
        .i_rec      (w_rdata),
        .o_best_idx (w_best_idx),
        .o_best_rec (w_best_rec)
    );

    // Sequencer: insert in one step, extract as scan then compaction.
    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_k       = r_k;
        n_valid   = 1'b0;
        n_status  = r_status;
        n_out     = r_out;
        w_we      = 1'b0;
        w_waddr   = r_k;
        w_wdata   = w_rdata;
        w_raddr   = w_k_next[IDX_W-1:0];
        w_min_ctl = '0;
        unique case (r_state)
            S_IDLE: begin
                w_raddr = '0;
                if (w_accept) begin
                    n_valid = 1'b1;
                    n_out   = '0;
                    if (i_op == OP_INSERT) begin
                        if (r_count == CNT_W'(CAPACITY)) begin
                            n_status = ST_FULL;
                        end else begin
                            w_we     = 1'b1;
                            w_waddr  = r_count[IDX_W-1:0];
                            w_wdata  = w_in_rec;
                            n_count  = r_count + CNT_W'(1);
                            n_status = ST_OK;
                        end
                    end else if (r_count == '0) begin
                        n_status = ST_EMPTY;
                    end else begin
                        n_valid = 1'b0;
                        n_k     = '0;
                        n_state = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                w_min_ctl.en    = 1'b1;
                w_min_ctl.first = (r_k == '0);
                n_k             = w_k_next[IDX_W-1:0];
                if (w_k_next == r_count) begin
                    n_state = S_CSTART;
                end
            end
            S_CSTART: begin
                w_raddr = w_best_idx + IDX_W'(1);
                n_k     = w_best_idx;
                n_state = S_COMPACT;
            end
            S_COMPACT: begin
                if (w_k_next < r_count) begin
                    // Move the entry behind position k down into k.
                    w_we    = 1'b1;
                    w_waddr = r_k;
                    w_wdata = w_rdata;
                    w_raddr = r_k + IDX_W'(2);
                    n_k     = w_k_next[IDX_W-1:0];
                end else begin
                    n_valid  = 1'b1;
                    n_status = ST_OK;
                    n_out    = w_best_rec;
                    n_count  = r_count - CNT_W'(1);
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_valid <= n_valid;
        end
    end

    // Scan index and result payload.
    always_ff @(posedge i_clk) begin
        r_k      <= n_k;
        r_status <= n_status;
        r_out    <= n_out;
    end

    assign o_valid        = r_valid;
    assign o_status       = r_status;
    assign o_out_id       = r_out.id;
    assign o_out_arrival  = r_out.arrival;
    assign o_out_service  = r_out.service;
    assign o_entries_left = LEFT_W'(r_count);

endmodule

### rtl/mkq_store.sv
module mkq_store #(
    parameter int CAPACITY = mkq_pkg::MKQ_CAPACITY
) (
    input  logic                        i_clk,
    input  logic                        i_we,
    input  logic [$clog2(CAPACITY)-1:0] i_waddr,
    input  mkq_pkg::t_rec               i_wdata,
    input  logic [$clog2(CAPACITY)-1:0] i_raddr,
    output mkq_pkg::t_rec               o_rdata
);
    import mkq_pkg::*;

    t_rec r_mem [CAPACITY];
    t_rec r_rdata;

    // Record memory: one write port, one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/mkq_min_unit.sv
module mkq_min_unit #(
    parameter int CAPACITY = mkq_pkg::MKQ_CAPACITY
) (
    input  logic                        i_clk,
    input  mkq_pkg::t_min_ctl           i_ctl,
    input  logic [$clog2(CAPACITY)-1:0] i_idx,
    input  mkq_pkg::t_rec               i_rec,
    output logic [$clog2(CAPACITY)-1:0] o_best_idx,
    output mkq_pkg::t_rec               o_best_rec
);
    import mkq_pkg::*;

    localparam int IDX_W = $clog2(CAPACITY);

    logic [IDX_W-1:0] r_best_idx;
    t_rec             r_best_rec;
    logic             w_take;

    // Shared key comparator. A strict compare keeps the oldest of equal ids.
    assign w_take = i_ctl.first || (i_rec.id < r_best_rec.id);

    // Running minimum over the records presented one per cycle.
    always_ff @(posedge i_clk) begin
        if (i_ctl.en && w_take) begin
            r_best_idx <= i_idx;
            r_best_rec <= i_rec;
        end
    end

    assign o_best_idx = r_best_idx;
    assign o_best_rec = r_best_rec;

endmodule
